[src/ssd_pkg.sv]
package ssd_pkg;

  localparam int OUT_W = 17;
  localparam logic [OUT_W-1:0] DIST_MAX = 17'h1FFFF;

  // 1.0 in raw coordinate-to-the-fourth units of Q12.4
  localparam int PARALLEL_ONE = 65536;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_DW-1:0] LIMIT_RST = 32'd6554;

  typedef enum logic {
    REG_PARALLEL_LIMIT = 1'b0,
    REG_ZERO_LIMIT     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic zero;
    logic one;
  } pflag_t;

endpackage

[src/ssd_mul.sv]
module ssd_mul #(
  parameter int W = 35
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int L   = W / 2;
  localparam int H   = W - L;
  localparam int PW2 = 2 * W;

  logic signed [H-1:0]     ah, bh;
  logic signed [L:0]       al, bl;
  logic signed [2*H-1:0]   hh_r;
  logic signed [H+L:0]     hl_r, lh_r;
  logic signed [2*L+1:0]   ll_r;
  logic signed [PW2-1:0]   p_r;

  assign ah = a[W-1:L];
  assign bh = b[W-1:L];
  assign al = {1'b0, a[L-1:0]};
  assign bl = {1'b0, b[L-1:0]};

  // partial products, then their weighted sum
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * bl;
      lh_r <= al * bh;
      ll_r <= al * bl;
      p_r  <= (PW2'(hh_r) <<< (2 * L)) + ((PW2'(hl_r) + PW2'(lh_r)) <<< L) + PW2'(ll_r);
    end
  end

  assign p = p_r;

endmodule

[src/segment_to_segment_distance_2d_unit.sv]
// Shortest distance between two 2D segments, one transaction per clock unless a stalled receiver freezes the pipeline.
//
// Input channel (in_valid/in_ready): the eight signed Q12.4 endpoint
// coordinates of both segments. Result channel (out_valid/out_ready): the
// distance in unsigned Q.4, rounded down and saturated to 17 bits.
// Configuration through the APB-style port: parallel_limit at byte address 0,
// zero_limit at byte address 4; write them only while the block is idle.
//
// The pipeline depth is set by the restoring divider, which retires one
// fraction bit per stage, and the square root, which retires one result
// bit per stage. Throughput is one transaction per cycle while a stalled
// receiver does not freeze the pipeline.
//
// Reset clears all valid bits and restores both limits to 6554. When the
// receiver stalls, the output register holds its transaction and the
// pipeline keeps filling its empty stages; once the last stage holds a
// transaction the whole pipeline freezes and in_ready drops.
module segment_to_segment_distance_2d_unit #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_first_start_x,
  input  logic signed [COORD_WIDTH-1:0]   in_first_start_y,
  input  logic signed [COORD_WIDTH-1:0]   in_first_end_x,
  input  logic signed [COORD_WIDTH-1:0]   in_first_end_y,
  input  logic signed [COORD_WIDTH-1:0]   in_second_start_x,
  input  logic signed [COORD_WIDTH-1:0]   in_second_start_y,
  input  logic signed [COORD_WIDTH-1:0]   in_second_end_x,
  input  logic signed [COORD_WIDTH-1:0]   in_second_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ssd_pkg::OUT_W-1:0]       out_distance,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssd_pkg::CFG_AW-1:0]      paddr,
  input  logic [ssd_pkg::CFG_DW-1:0]      pwdata,
  output logic [ssd_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int OW  = ssd_pkg::OUT_W;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW + 1;
  localparam int QW  = 2 * PW + 1;
  localparam int GW  = 6 * DW;
  localparam int SW  = F + 1;
  localparam int XW  = DW + F + 2;
  localparam int MW  = XW - 1;
  localparam int N2W = 2 * MW + 1;
  localparam int MLW = N2W - 2 * F;
  localparam int SQW = 2 * OW;
  localparam int EXW = (MLW > SQW) ? MLW : SQW + 1;
  localparam int RW  = OW + 2;
  localparam int GS  = 10 + F;
  localparam int NST = 14 + F + OW;

  // ---------------- configuration ----------------
  logic [ssd_pkg::CFG_DW-1:0] par_lim_r, zero_lim_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_lim_r  <= ssd_pkg::LIMIT_RST;
      zero_lim_r <= ssd_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (ssd_pkg::cfg_reg_t'(paddr[2]))
        ssd_pkg::REG_PARALLEL_LIMIT: par_lim_r  <= pwdata;
        ssd_pkg::REG_ZERO_LIMIT:     zero_lim_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ssd_pkg::cfg_reg_t'(paddr[2]))
      ssd_pkg::REG_PARALLEL_LIMIT: prdata = par_lim_r;
      ssd_pkg::REG_ZERO_LIMIT:     prdata = zero_lim_r;
      default:                     prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [NST:1]  vld_r;
  logic          adv;
  logic          out_valid_r;
  logic [OW-1:0] out_dist_r;

  // advance unless the last stage would have nowhere to go
  assign adv      = out_ready | ~out_valid_r | ~vld_r[NST];
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_valid};
    end
  end

  // ---------------- stage 1: direction and offset vectors ----------------
  logic [GW-1:0] geo_r [1:GS];
  logic [GW-1:0] geo_nxt;

  assign geo_nxt = {DW'(in_first_end_x)    - DW'(in_first_start_x),
                    DW'(in_first_end_y)    - DW'(in_first_start_y),
                    DW'(in_second_end_x)   - DW'(in_second_start_x),
                    DW'(in_second_end_y)   - DW'(in_second_start_y),
                    DW'(in_first_start_x)  - DW'(in_second_start_x),
                    DW'(in_first_start_y)  - DW'(in_second_start_y)};

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_r[1] <= geo_nxt;
      for (int k = 2; k <= GS; k++) begin
        geo_r[k] <= geo_r[k-1];
      end
    end
  end

  // ---------------- stage 2: coordinate products ----------------
  logic signed [DW-1:0] ux1, uy1, vx1, vy1, wx1, wy1;
  logic signed [2*DW-1:0] m_uux_r, m_uuy_r, m_uvx_r, m_uvy_r, m_vvx_r, m_vvy_r;
  logic signed [2*DW-1:0] m_uwx_r, m_uwy_r, m_vwx_r, m_vwy_r;

  assign ux1 = geo_r[1][6*DW-1 -: DW];
  assign uy1 = geo_r[1][5*DW-1 -: DW];
  assign vx1 = geo_r[1][4*DW-1 -: DW];
  assign vy1 = geo_r[1][3*DW-1 -: DW];
  assign wx1 = geo_r[1][2*DW-1 -: DW];
  assign wy1 = geo_r[1][DW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      m_uux_r <= ux1 * ux1;
      m_uuy_r <= uy1 * uy1;
      m_uvx_r <= ux1 * vx1;
      m_uvy_r <= uy1 * vy1;
      m_vvx_r <= vx1 * vx1;
      m_vvy_r <= vy1 * vy1;
      m_uwx_r <= ux1 * wx1;
      m_uwy_r <= uy1 * wy1;
      m_vwx_r <= vx1 * wx1;
      m_vwy_r <= vy1 * wy1;
    end
  end

  // ---------------- stage 3: dot products a, b, c, d, e ----------------
  logic [5*PW-1:0] dot_r [3:7];

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r[3] <= {PW'(m_uux_r) + PW'(m_uuy_r),
                   PW'(m_uvx_r) + PW'(m_uvy_r),
                   PW'(m_vvx_r) + PW'(m_vvy_r),
                   PW'(m_uwx_r) + PW'(m_uwy_r),
                   PW'(m_vwx_r) + PW'(m_vwy_r)};
      for (int k = 4; k <= 7; k++) begin
        dot_r[k] <= dot_r[k-1];
      end
    end
  end

  logic signed [PW-1:0] a3, b3, c3, d3, e3;
  assign a3 = dot_r[3][5*PW-1 -: PW];
  assign b3 = dot_r[3][4*PW-1 -: PW];
  assign c3 = dot_r[3][3*PW-1 -: PW];
  assign d3 = dot_r[3][2*PW-1 -: PW];
  assign e3 = dot_r[3][PW-1:0];

  // ---------------- stages 4-5: wide products ----------------
  logic signed [2*PW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  ssd_mul #(.W(PW)) u_mul_ac (.clk(clk), .en(adv), .a(a3), .b(c3), .p(p_ac));
  ssd_mul #(.W(PW)) u_mul_bb (.clk(clk), .en(adv), .a(b3), .b(b3), .p(p_bb));
  ssd_mul #(.W(PW)) u_mul_be (.clk(clk), .en(adv), .a(b3), .b(e3), .p(p_be));
  ssd_mul #(.W(PW)) u_mul_cd (.clk(clk), .en(adv), .a(c3), .b(d3), .p(p_cd));
  ssd_mul #(.W(PW)) u_mul_ae (.clk(clk), .en(adv), .a(a3), .b(e3), .p(p_ae));
  ssd_mul #(.W(PW)) u_mul_bd (.clk(clk), .en(adv), .a(b3), .b(d3), .p(p_bd));

  // ---------------- stage 6: determinant and raw numerators ----------------
  logic signed [QW-1:0] det6_r, sn6_r, tn6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      det6_r <= QW'(p_ac) - QW'(p_bb);
      sn6_r  <= QW'(p_be) - QW'(p_cd);
      tn6_r  <= QW'(p_ae) - QW'(p_bd);
    end
  end

  // ---------------- stage 7: parallel test and first clamp ----------------
  logic signed [PW-1:0] b6, c6, e6;
  logic signed [QW-1:0] plim, sn7, sd7, tn7, td7;
  logic signed [QW-1:0] sn7_r, sd7_r, tn7_r, td7_r;

  assign b6   = dot_r[6][4*PW-1 -: PW];
  assign c6   = dot_r[6][3*PW-1 -: PW];
  assign e6   = dot_r[6][PW-1:0];
  assign plim = QW'($signed({1'b0, par_lim_r}));

  always_comb begin
    sn7 = sn6_r;
    sd7 = det6_r;
    tn7 = tn6_r;
    td7 = det6_r;
    if (det6_r < plim) begin
      sn7 = '0;
      sd7 = QW'(ssd_pkg::PARALLEL_ONE);
      tn7 = QW'(e6);
      td7 = QW'(c6);
    end else if (sn6_r[QW-1]) begin
      sn7 = '0;
      tn7 = QW'(e6);
      td7 = QW'(c6);
    end else if (det6_r < sn6_r) begin
      sn7 = det6_r;
      tn7 = QW'(e6) + QW'(b6);
      td7 = QW'(c6);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn7_r <= sn7;
      sd7_r <= sd7;
      tn7_r <= tn7;
      td7_r <= td7;
    end
  end

  // ---------------- stage 8: clamp second parameter, redo first ----------------
  logic signed [PW-1:0] a7, b7, d7;
  logic signed [PW:0]   n8;
  logic                 redo;
  logic signed [QW-1:0] sn8, sd8, tn8;
  logic signed [QW-1:0] sn8_r, sd8_r, tn8_r, td8_r;

  assign a7 = dot_r[7][5*PW-1 -: PW];
  assign b7 = dot_r[7][4*PW-1 -: PW];
  assign d7 = dot_r[7][2*PW-1 -: PW];

  always_comb begin
    sn8  = sn7_r;
    sd8  = sd7_r;
    tn8  = tn7_r;
    redo = 1'b0;
    n8   = '0;
    if (tn7_r[QW-1]) begin
      tn8  = '0;
      redo = 1'b1;
      n8   = -(PW+1)'(d7);
    end else if (td7_r < tn7_r) begin
      tn8  = td7_r;
      redo = 1'b1;
      n8   = (PW+1)'(b7) - (PW+1)'(d7);
    end
    if (redo) begin
      if (n8[PW]) begin
        sn8 = '0;
      end else if (n8 > (PW+1)'(a7)) begin
        sn8 = sd7_r;
      end else begin
        sn8 = QW'(n8);
        sd8 = QW'(a7);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn8_r <= sn8;
      sd8_r <= sd8;
      tn8_r <= tn8;
      td8_r <= td7_r;
    end
  end

  // ---------------- stages 9 .. 9+F: fraction dividers ----------------
  logic [QW-1:0]    rs_r [0:F];
  logic [QW-1:0]    ds_r [0:F];
  logic [QW-1:0]    rt_r [0:F];
  logic [QW-1:0]    dt_r [0:F];
  logic [F-1:0]     qs_r [0:F];
  logic [F-1:0]     qt_r [0:F];
  ssd_pkg::pflag_t  fs_r [0:F];
  ssd_pkg::pflag_t  ft_r [0:F];
  logic signed [QW-1:0] zlim;
  ssd_pkg::pflag_t  fs_nxt, ft_nxt;

  assign zlim = QW'($signed({1'b0, zero_lim_r}));

  always_comb begin
    fs_nxt.zero = sn8_r[QW-1] | (sn8_r < zlim) | sd8_r[QW-1] | (sd8_r == '0);
    fs_nxt.one  = (sn8_r >= sd8_r);
    ft_nxt.zero = tn8_r[QW-1] | (tn8_r < zlim) | td8_r[QW-1] | (td8_r == '0);
    ft_nxt.one  = (tn8_r >= td8_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_r[0] <= sn8_r;
      ds_r[0] <= sd8_r;
      rt_r[0] <= tn8_r;
      dt_r[0] <= td8_r;
      qs_r[0] <= '0;
      qt_r[0] <= '0;
      fs_r[0] <= fs_nxt;
      ft_r[0] <= ft_nxt;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [QW-1:0] shs, sht;
    logic          ges, get;

    assign shs = {rs_r[k-1][QW-2:0], 1'b0};
    assign sht = {rt_r[k-1][QW-2:0], 1'b0};
    assign ges = (shs >= ds_r[k-1]);
    assign get = (sht >= dt_r[k-1]);

    always_ff @(posedge clk) begin
      if (adv) begin
        rs_r[k] <= ges ? shs - ds_r[k-1] : shs;
        rt_r[k] <= get ? sht - dt_r[k-1] : sht;
        qs_r[k] <= {qs_r[k-1][F-2:0], ges};
        qt_r[k] <= {qt_r[k-1][F-2:0], get};
        ds_r[k] <= ds_r[k-1];
        dt_r[k] <= dt_r[k-1];
        fs_r[k] <= fs_r[k-1];
        ft_r[k] <= ft_r[k-1];
      end
    end
  end

  // ---------------- stage 10+F: scale direction vectors ----------------
  logic [SW-1:0]        sc, tc;
  logic signed [DW-1:0] uxp, uyp, vxp, vyp;
  logic signed [XW-1:0] p_usx_r, p_usy_r, p_vtx_r, p_vty_r;

  always_comb begin
    if (fs_r[F].zero) begin
      sc = '0;
    end else if (fs_r[F].one) begin
      sc = SW'(1) << F;
    end else begin
      sc = {1'b0, qs_r[F]};
    end
    if (ft_r[F].zero) begin
      tc = '0;
    end else if (ft_r[F].one) begin
      tc = SW'(1) << F;
    end else begin
      tc = {1'b0, qt_r[F]};
    end
  end

  assign uxp = geo_r[9+F][6*DW-1 -: DW];
  assign uyp = geo_r[9+F][5*DW-1 -: DW];
  assign vxp = geo_r[9+F][4*DW-1 -: DW];
  assign vyp = geo_r[9+F][3*DW-1 -: DW];

  always_ff @(posedge clk) begin
    if (adv) begin
      p_usx_r <= uxp * $signed({1'b0, sc});
      p_usy_r <= uyp * $signed({1'b0, sc});
      p_vtx_r <= vxp * $signed({1'b0, tc});
      p_vty_r <= vyp * $signed({1'b0, tc});
    end
  end

  // ---------------- stage 11+F: difference vector magnitudes ----------------
  logic signed [DW-1:0] wxp, wyp;
  logic signed [XW-1:0] dx, dy;
  logic [MW-1:0]        mx_r, my_r;

  assign wxp = geo_r[10+F][2*DW-1 -: DW];
  assign wyp = geo_r[10+F][DW-1:0];
  assign dx  = (XW'(wxp) <<< F) + p_usx_r - p_vtx_r;
  assign dy  = (XW'(wyp) <<< F) + p_usy_r - p_vty_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r <= dx[XW-1] ? MW'(-dx) : MW'(dx);
      my_r <= dy[XW-1] ? MW'(-dy) : MW'(dy);
    end
  end

  // ---------------- stages 12+F, 13+F: squares ----------------
  logic signed [2*MW+1:0] sqx, sqy;

  ssd_mul #(.W(MW+1)) u_sq_x (.clk(clk), .en(adv), .a($signed({1'b0, mx_r})),
                              .b($signed({1'b0, mx_r})), .p(sqx));
  ssd_mul #(.W(MW+1)) u_sq_y (.clk(clk), .en(adv), .a($signed({1'b0, my_r})),
                              .b($signed({1'b0, my_r})), .p(sqy));

  // ---------------- stage 14+F: drop fraction bits, saturation test ----------------
  logic [N2W-1:0] n2;
  logic [EXW-1:0] mext;
  logic [RW-1:0]  rem_r  [0:OW];
  logic [OW-1:0]  root_r [0:OW];
  logic [SQW-1:0] mm_r   [0:OW];
  logic           sat_r  [0:OW];

  assign n2   = {1'b0, sqx[2*MW-1:0]} + {1'b0, sqy[2*MW-1:0]};
  assign mext = EXW'(n2[N2W-1:2*F]);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      mm_r[0]   <= mext[SQW-1:0];
      sat_r[0]  <= |mext[EXW-1:SQW];
    end
  end

  // ---------------- stages 15+F ..: square root, one bit per stage ----------------
  for (genvar j = 1; j <= OW; j++) begin : g_sqrt
    logic [RW-1:0] remn, trial;
    logic          ge;

    assign remn  = {rem_r[j-1][RW-3:0], mm_r[j-1][SQW-1:SQW-2]};
    assign trial = {root_r[j-1], 2'b01};
    assign ge    = (remn >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= ge ? remn - trial : remn;
        root_r[j] <= {root_r[j-1][OW-2:0], ge};
        mm_r[j]   <= {mm_r[j-1][SQW-3:0], 2'b00};
        sat_r[j]  <= sat_r[j-1];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vld_r[NST]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[NST]) begin
      out_dist_r <= sat_r[OW] ? ssd_pkg::DIST_MAX : root_r[OW];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;

endmodule

[src/ssd_checker.sv]
module ssd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ssd_pkg::OUT_W-1:0]   out_distance,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready,
  input logic [ssd_pkg::CFG_AW-1:0]  paddr,
  input logic [ssd_pkg::CFG_DW-1:0]  pwdata,
  input logic [ssd_pkg::CFG_DW-1:0]  prdata
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // with the output register empty the block must take a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while output register empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("stalled result changed or dropped");

  a_limit_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready &&
    ssd_pkg::cfg_reg_t'(paddr[2]) == ssd_pkg::REG_PARALLEL_LIMIT
    |=> ssd_pkg::cfg_reg_t'(paddr[2]) != ssd_pkg::REG_PARALLEL_LIMIT ||
        prdata == $past(pwdata))
    else $error("parallel_limit readback mismatch");

endmodule

bind segment_to_segment_distance_2d_unit ssd_checker u_ssd_checker (.*);
